FILE: src/v86_mon_pkg.sv
// Package with the types and constants of the virtual-8086 instruction monitor.
`default_nettype none

package v86_mon_pkg;

  // Number of 0x66 / 0x67 prefixes accepted ahead of an opcode (0 to 2).
  localparam int unsigned MaxPrefixes = 2;
  localparam int unsigned PreCntW     = $clog2(MaxPrefixes + 1);
  localparam int unsigned ByteIdxW    = 3;

  localparam logic [7:0] OPC_INT      = 8'hCD;
  localparam logic [7:0] OPC_LOCK     = 8'hF0;
  localparam logic [7:0] OPC_PUSHF    = 8'h9C;
  localparam logic [7:0] OPC_POPF     = 8'h9D;
  localparam logic [7:0] OPC_CLI      = 8'hFA;
  localparam logic [7:0] OPC_STI      = 8'hFB;
  localparam logic [7:0] OPC_IRET     = 8'hCF;
  localparam logic [7:0] OPC_IN_AL    = 8'hEC;
  localparam logic [7:0] OPC_IN_AX    = 8'hED;
  localparam logic [7:0] OPC_OUT_AL   = 8'hEE;
  localparam logic [7:0] OPC_OUT_AX   = 8'hEF;
  localparam logic [7:0] OPC_HLT      = 8'hF4;
  localparam logic [7:0] PFX_OPSIZE   = 8'h66;
  localparam logic [7:0] PFX_ADSIZE   = 8'h67;

  localparam logic [7:0] VEC_EXIT     = 8'h69;
  localparam logic [7:0] VEC_DOS_TERM = 8'h20;
  localparam logic [7:0] VEC_DOS_CALL = 8'h21;

  localparam logic [31:0] FLAG_IF      = 32'h0000_0200;
  localparam logic [31:0] FLAG_VM      = 32'h0002_0000;
  localparam logic [31:0] PUSHF32_MASK = 32'h0000_0DFF;
  localparam int unsigned FlagIfBit    = 9;

  typedef enum logic [2:0] {
    PORT_NONE    = 3'd0,
    PORT_IN_BYTE = 3'd1,
    PORT_IN_WORD = 3'd2,
    PORT_OUT_BYTE = 3'd3,
    PORT_OUT_WORD = 3'd4
  } port_op_e;

  typedef enum logic [1:0] {
    TMARK_NONE  = 2'd0,
    TMARK_SET   = 2'd1,
    TMARK_CLEAR = 2'd2
  } timer_mark_e;

  typedef enum logic [2:0] {
    ST_HANDLED   = 3'd0,
    ST_EXIT      = 3'd1,
    ST_FORBIDDEN = 3'd2,
    ST_LOCK      = 3'd3,
    ST_UNHANDLED = 3'd4
  } status_e;

  typedef struct packed {
    logic [31:0] instr_bytes;
    logic [15:0] code_seg;
    logic [15:0] instr_ptr;
    logic [15:0] stack_ptr;
    logic [31:0] flags_in;
    logic        virt_if_in;
    logic [15:0] acc_in;
    logic [15:0] port_addr;
    logic [47:0] stack_words;
    logic [31:0] vector_entry;
    logic [15:0] port_read_data;
  } in_req_t;

  typedef struct packed {
    logic [15:0] code_seg_out;
    logic [15:0] instr_ptr_out;
    logic [15:0] stack_ptr_out;
    logic [31:0] flags_out;
    logic        virt_if_out;
    logic [15:0] acc_out;
    logic [47:0] push_data;
    logic [1:0]  push_words;
    port_op_e    port_op;
    logic [15:0] port_write_data;
    timer_mark_e timer_mark;
    status_e     status;
  } out_req_t;

endpackage

`default_nettype wire

FILE: src/v86_sensitive_instruction_monitor_unit.sv
// Top level of the virtual-8086 sensitive instruction monitor.
`default_nettype none

// The monitor takes one trapped virtual-8086 instruction per request, together
// with the task's register snapshot, the three stack words at SS:SP, the vector
// table entry for INT n and the port read data for IN, and returns one result
// request with the new CS, IP, SP, flags, virtual IF and AX, the words to push,
// the port operation and a status. Up to two 0x66/0x67 prefixes are skipped;
// only 0x66 matters, and only for PUSHF and POPF. A request is first held in
// the input register, then the decode and emulation logic writes the result
// register. The two registers form a short pipeline, so a new request is
// accepted every cycle as long as the consumer takes results; in_stall_o rises
// only when both registers are full and the consumer stalls. There is no state
// carried from one request to the next and nothing to configure; after reset
// both pipeline stages are empty.
module v86_sensitive_instruction_monitor_unit (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire v86_mon_pkg::in_req_t    in_req_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output v86_mon_pkg::out_req_t        out_req_o
);

  // Pipeline control: the result stage moves when it is empty or its request is
  // being taken; the input stage moves when it is empty or its request can pass.
  logic                 in_valid_q;
  v86_mon_pkg::in_req_t in_req_q;
  logic                 out_valid_q;
  v86_mon_pkg::out_req_t out_req_q;
  v86_mon_pkg::out_req_t res_d;
  logic                 out_adv;
  logic                 in_adv;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_stall_o = !in_adv;

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers carry no reset; they load only when their stage moves.
  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      in_req_q <= in_req_i;
    end
    if (out_adv && in_valid_q) begin
      out_req_q <= res_d;
    end
  end

  // Returns instruction byte idx, or zero beyond the four fetched bytes.
  function automatic logic [7:0] fetch_byte(input logic [31:0] bytes,
                                            input logic [v86_mon_pkg::ByteIdxW-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx <= v86_mon_pkg::ByteIdxW'(3)) begin
      b = bytes[8*idx[1:0] +: 8];
    end
    return b;
  endfunction

  // Decode and emulation of the instruction held in the input register.
  always_comb begin
    logic                               scan;
    logic                               op32;
    logic [v86_mon_pkg::PreCntW-1:0]    npre;
    logic [v86_mon_pkg::ByteIdxW-1:0]   pos;
    logic [7:0]                         pfx;
    logic [7:0]                         opc;
    logic [7:0]                         vec_num;
    logic [15:0]                        ip_pre;
    logic [15:0]                        w0;
    logic [15:0]                        w1;
    logic [15:0]                        w2;
    logic [31:0]                        flags_vif;

    scan = 1'b1;
    op32 = 1'b0;
    npre = '0;
    for (int i = 0; i < v86_mon_pkg::MaxPrefixes; i++) begin
      pfx = fetch_byte(in_req_q.instr_bytes, v86_mon_pkg::ByteIdxW'(i));
      if (scan && (pfx == v86_mon_pkg::PFX_OPSIZE || pfx == v86_mon_pkg::PFX_ADSIZE)) begin
        if (pfx == v86_mon_pkg::PFX_OPSIZE) begin
          op32 = 1'b1;
        end
        npre = npre + v86_mon_pkg::PreCntW'(1);
      end else begin
        scan = 1'b0;
      end
    end
    pos     = v86_mon_pkg::ByteIdxW'(npre);
    opc     = fetch_byte(in_req_q.instr_bytes, pos);
    vec_num = fetch_byte(in_req_q.instr_bytes, pos + v86_mon_pkg::ByteIdxW'(1));
    ip_pre  = in_req_q.instr_ptr + 16'(npre);
    w0      = in_req_q.stack_words[15:0];
    w1      = in_req_q.stack_words[31:16];
    w2      = in_req_q.stack_words[47:32];

    // Flags as the task sees them: the real IF bit replaced by the virtual IF.
    flags_vif = in_req_q.flags_in;
    flags_vif[v86_mon_pkg::FlagIfBit] = in_req_q.virt_if_in;

    res_d.code_seg_out    = in_req_q.code_seg;
    res_d.instr_ptr_out   = ip_pre;
    res_d.stack_ptr_out   = in_req_q.stack_ptr;
    res_d.flags_out       = in_req_q.flags_in;
    res_d.virt_if_out     = in_req_q.virt_if_in;
    res_d.acc_out         = in_req_q.acc_in;
    res_d.push_data       = '0;
    res_d.push_words      = 2'd0;
    res_d.port_op         = v86_mon_pkg::PORT_NONE;
    res_d.port_write_data = '0;
    res_d.timer_mark      = v86_mon_pkg::TMARK_NONE;
    res_d.status          = v86_mon_pkg::ST_HANDLED;

    case (opc)
      v86_mon_pkg::OPC_INT: begin
        if (vec_num == v86_mon_pkg::VEC_EXIT) begin
          res_d.status = v86_mon_pkg::ST_EXIT;
        end else if (vec_num == v86_mon_pkg::VEC_DOS_TERM ||
                     vec_num == v86_mon_pkg::VEC_DOS_CALL) begin
          res_d.status = v86_mon_pkg::ST_FORBIDDEN;
        end else begin
          res_d.stack_ptr_out = in_req_q.stack_ptr - 16'd6;
          res_d.push_data     = {flags_vif[15:0], in_req_q.code_seg, ip_pre + 16'd2};
          res_d.push_words    = 2'd3;
          res_d.code_seg_out  = in_req_q.vector_entry[31:16];
          res_d.instr_ptr_out = in_req_q.vector_entry[15:0];
        end
      end
      v86_mon_pkg::OPC_LOCK: begin
        res_d.instr_ptr_out = ip_pre + 16'd1;
        res_d.status        = v86_mon_pkg::ST_LOCK;
      end
      v86_mon_pkg::OPC_PUSHF: begin
        if (op32) begin
          res_d.stack_ptr_out = in_req_q.stack_ptr - 16'd4;
          res_d.push_data     = {16'h0000, flags_vif & (v86_mon_pkg::PUSHF32_MASK |
                                                        v86_mon_pkg::FLAG_IF)};
          res_d.push_words    = 2'd2;
        end else begin
          res_d.stack_ptr_out = in_req_q.stack_ptr - 16'd2;
          res_d.push_data     = {32'h0000_0000, flags_vif[15:0]};
          res_d.push_words    = 2'd1;
        end
        res_d.instr_ptr_out = ip_pre + 16'd1;
      end
      v86_mon_pkg::OPC_POPF: begin
        if (op32) begin
          res_d.flags_out     = v86_mon_pkg::FLAG_IF | v86_mon_pkg::FLAG_VM |
                                ({16'h0000, w0} & v86_mon_pkg::PUSHF32_MASK);
          res_d.stack_ptr_out = in_req_q.stack_ptr + 16'd4;
        end else begin
          res_d.flags_out     = v86_mon_pkg::FLAG_IF | v86_mon_pkg::FLAG_VM | {16'h0000, w0};
          res_d.stack_ptr_out = in_req_q.stack_ptr + 16'd2;
        end
        res_d.virt_if_out   = w0[v86_mon_pkg::FlagIfBit];
        res_d.instr_ptr_out = ip_pre + 16'd1;
      end
      v86_mon_pkg::OPC_CLI: begin
        res_d.virt_if_out   = 1'b0;
        res_d.flags_out     = in_req_q.flags_in & ~v86_mon_pkg::FLAG_IF;
        res_d.instr_ptr_out = ip_pre + 16'd1;
        res_d.timer_mark    = v86_mon_pkg::TMARK_SET;
      end
      v86_mon_pkg::OPC_STI: begin
        res_d.virt_if_out   = 1'b1;
        res_d.flags_out     = in_req_q.flags_in | v86_mon_pkg::FLAG_IF;
        res_d.instr_ptr_out = ip_pre + 16'd1;
        res_d.timer_mark    = v86_mon_pkg::TMARK_CLEAR;
      end
      v86_mon_pkg::OPC_IRET: begin
        res_d.instr_ptr_out = w0;
        res_d.code_seg_out  = w1;
        res_d.flags_out     = v86_mon_pkg::FLAG_IF | v86_mon_pkg::FLAG_VM | {16'h0000, w2};
        res_d.virt_if_out   = w2[v86_mon_pkg::FlagIfBit];
        res_d.stack_ptr_out = in_req_q.stack_ptr + 16'd6;
      end
      v86_mon_pkg::OPC_IN_AL: begin
        res_d.acc_out       = {in_req_q.acc_in[15:8], in_req_q.port_read_data[7:0]};
        res_d.port_op       = v86_mon_pkg::PORT_IN_BYTE;
        res_d.instr_ptr_out = ip_pre + 16'd1;
      end
      v86_mon_pkg::OPC_IN_AX: begin
        res_d.acc_out       = in_req_q.port_read_data;
        res_d.port_op       = v86_mon_pkg::PORT_IN_WORD;
        res_d.instr_ptr_out = ip_pre + 16'd1;
      end
      v86_mon_pkg::OPC_OUT_AL: begin
        res_d.port_op         = v86_mon_pkg::PORT_OUT_BYTE;
        res_d.port_write_data = {8'h00, in_req_q.acc_in[7:0]};
        res_d.instr_ptr_out   = ip_pre + 16'd1;
      end
      v86_mon_pkg::OPC_OUT_AX: begin
        res_d.port_op         = v86_mon_pkg::PORT_OUT_WORD;
        res_d.port_write_data = in_req_q.acc_in;
        res_d.instr_ptr_out   = ip_pre + 16'd1;
      end
      v86_mon_pkg::OPC_HLT: begin
        res_d.instr_ptr_out = ip_pre + 16'd1;
      end
      default: begin
        res_d.status = v86_mon_pkg::ST_UNHANDLED;
      end
    endcase
  end

  // A request that finds both stages empty is in the input register next cycle.
  a_fill_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_valid_q |=> in_valid_q)
    else $error("accepted request did not reach the input register");

  // A full input register moves on whenever the result stage can take it.
  a_drain_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_stall_i |=> out_valid_q)
    else $error("input register did not pass its request on");

  // Only handled instructions write to the stack.
  a_push_only_handled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.push_words != 2'd0 |-> out_req_o.status == v86_mon_pkg::ST_HANDLED)
    else $error("stack push reported with a non-handled status");

  // CLI and STI leave the virtual IF matching their timer mark.
  a_timer_vif: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.timer_mark != v86_mon_pkg::TMARK_NONE |->
      out_req_o.virt_if_out == (out_req_o.timer_mark == v86_mon_pkg::TMARK_CLEAR))
    else $error("virtual IF disagrees with timer mark");

  // Write data is present only for an OUT request.
  a_write_data_out_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.port_op != v86_mon_pkg::PORT_OUT_BYTE &&
    out_req_o.port_op != v86_mon_pkg::PORT_OUT_WORD |-> out_req_o.port_write_data == 16'h0000)
    else $error("port write data without an OUT request");

endmodule

`default_nettype wire
